/* rtl/node_bandwidth_rate_meter_macros.svh */
// Assertion helpers shared by the meter modules.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef NODE_BANDWIDTH_RATE_METER_MACROS_SVH
`define NODE_BANDWIDTH_RATE_METER_MACROS_SVH

// Same-cycle implication.
`define NBRM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nbrm assertion failed");

// Next-cycle implication.
`define NBRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nbrm assertion failed");

`endif

/* rtl/nbrm_pkg.sv */
package nbrm_pkg;

  localparam int MaxNodes     = 4;
  localparam int NodesDefault = 4;
  localparam int AddrW        = 5;
  localparam int DataW        = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd1;
  localparam logic [2:0] REG_ACTIVE   = 3'd2;
  localparam logic [2:0] REG_MAX0     = 3'd3;
  localparam logic [2:0] REG_MAX1     = 3'd4;
  localparam logic [2:0] REG_MAX2     = 3'd5;
  localparam logic [2:0] REG_MAX3     = 3'd6;

  localparam logic [1:0] MODE_BYTES = 2'd0;
  localparam logic [1:0] MODE_PAGES = 2'd1;

  // Sample status codes
  localparam logic [2:0] ST_BASELINE  = 3'd0;
  localparam logic [2:0] ST_EARLY     = 3'd1;
  localparam logic [2:0] ST_ZERO_TIME = 3'd2;
  localparam logic [2:0] ST_COMPUTED  = 3'd3;
  localparam logic [2:0] ST_BACKWARDS = 3'd4;
  localparam logic [2:0] ST_MANUAL    = 3'd5;
  localparam logic [2:0] ST_BAD_NODE  = 3'd6;

  localparam logic [15:0] IntervalReset = 16'd100;
  localparam logic [2:0]  ActiveReset   = 3'd4;
  localparam logic [19:0] MaxBwReset    = 20'd50000;

  // bytes: delta * 1e6 / 2^12 = delta * 15625 / 2^6; pages: delta * 1e6
  localparam logic [19:0] ScaleBytes = 20'd15625;
  localparam logic [19:0] ScalePages = 20'd1000000;
  localparam logic [9:0]  MsToUs     = 10'd1000;

  localparam logic [31:0] BwSat     = 32'hFFFF_FFFF;
  localparam logic [16:0] UsageOne  = 17'd65536;
  localparam logic [16:0] UsageHalf = 17'd32768;

  localparam int DivBwSteps  = 32;
  localparam int DivUseSteps = 16;
  localparam int StepW       = $clog2(DivBwSteps);

  typedef struct packed {
    logic [1:0]            mode;
    logic [15:0]           interval_ms;
    logic [2:0]            active_nodes;
    logic [MaxNodes-1:0][19:0] max_bw;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic diff;
    logic decide;
    logic mul_lo;
    logic mul_hi;
    logic pre_bw;
    logic div_step;
    logic take_bw;
    logic pre_use;
    logic take_use;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic measure;
    logic sat;
    logic use_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/node_bandwidth_rate_meter.sv */
// Per-node memory bandwidth meter.
// Input channel (in_valid_i / in_stall_o): one sample per transfer, holding
// the node index, that node's running traffic counter and a timestamp in us.
// Output channel (out_valid_o / out_stall_i): exactly one result per sample,
// in order: node, status, bandwidth in MB/s (Q24.8) and usage (Q1.16).
// Configuration sits behind the APB port; write it only while idle.
// A sample that needs no arithmetic (bad node, manual mode, baseline, too
// early, zero time, counter backwards) passes the difference and decision
// steps and goes to the output register. A measured sample adds two 32x20
// partial products, then the shared one-bit-per-cycle divider runs 32 steps
// for the bandwidth and 16 for the usage; that divider sets the rate.
// The input stalls while a sample is in work; the next sample is taken as
// soon as the previous result sits in the output register, even if the
// receiver is stalling. A finished result waits if the output register is
// full and stalled. Reset clears the registers to their defaults and marks every
// node as having no baseline; held bandwidth and usage read as zero.
module node_bandwidth_rate_meter import nbrm_pkg::*; #(
  parameter int NODES = NodesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       node_index_i,
  input  logic [63:0]      traffic_count_i,
  input  logic [63:0]      time_us_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       node_out_o,
  output logic [2:0]       sample_status_o,
  output logic [31:0]      bandwidth_q8_o,
  output logic [16:0]      usage_q16_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  nbrm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nbrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nbrm_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .node_index_i    (node_index_i),
    .traffic_count_i (traffic_count_i),
    .time_us_i       (time_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .node_out_o      (node_out_o),
    .sample_status_o (sample_status_o),
    .bandwidth_q8_o  (bandwidth_q8_o),
    .usage_q16_o     (usage_q16_o)
  );

endmodule

/* rtl/nbrm_regs.sv */
module nbrm_regs import nbrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_BYTES;
      cfg_q.interval_ms  <= IntervalReset;
      cfg_q.active_nodes <= ActiveReset;
      for (int i = 0; i < MaxNodes; i++) begin
        cfg_q.max_bw[i] <= MaxBwReset;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:     cfg_q.mode         <= pwdata[1:0];
        REG_INTERVAL: cfg_q.interval_ms  <= pwdata[15:0];
        REG_ACTIVE:   cfg_q.active_nodes <= pwdata[2:0];
        REG_MAX0:     cfg_q.max_bw[0]    <= pwdata[19:0];
        REG_MAX1:     cfg_q.max_bw[1]    <= pwdata[19:0];
        REG_MAX2:     cfg_q.max_bw[2]    <= pwdata[19:0];
        REG_MAX3:     cfg_q.max_bw[3]    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:     prdata = {30'd0, cfg_q.mode};
      REG_INTERVAL: prdata = {16'd0, cfg_q.interval_ms};
      REG_ACTIVE:   prdata = {29'd0, cfg_q.active_nodes};
      REG_MAX0:     prdata = {12'd0, cfg_q.max_bw[0]};
      REG_MAX1:     prdata = {12'd0, cfg_q.max_bw[1]};
      REG_MAX2:     prdata = {12'd0, cfg_q.max_bw[2]};
      REG_MAX3:     prdata = {12'd0, cfg_q.max_bw[3]};
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/nbrm_ctrl.sv */
`include "node_bandwidth_rate_meter_macros.svh"

module nbrm_ctrl import nbrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIFF    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_MUL_LO  = 4'd3;
  localparam logic [3:0] S_MUL_HI  = 4'd4;
  localparam logic [3:0] S_PRE_BW  = 4'd5;
  localparam logic [3:0] S_DIV_BW  = 4'd6;
  localparam logic [3:0] S_PRE_USE = 4'd7;
  localparam logic [3:0] S_DIV_USE = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.measure ? S_MUL_LO : S_DONE;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_PRE_BW;
      end
      S_PRE_BW: begin
        cmd_o.pre_bw = 1'b1;
        if (sts_i.sat) begin
          state_d = S_PRE_USE;
        end else begin
          step_d  = StepW'(DivBwSteps - 1);
          state_d = S_DIV_BW;
        end
      end
      S_DIV_BW: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          cmd_o.take_bw = 1'b1;
          state_d       = S_PRE_USE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_PRE_USE: begin
        cmd_o.pre_use = 1'b1;
        if (sts_i.use_done) begin
          state_d = S_DONE;
        end else begin
          step_d  = StepW'(DivUseSteps - 1);
          state_d = S_DIV_USE;
        end
      end
      S_DIV_USE: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          cmd_o.take_use = 1'b1;
          state_d        = S_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `NBRM_ASSERT_NEXT(a_done_to_idle, state_q == S_DONE && sts_i.out_free, state_q == S_IDLE)
  `NBRM_ASSERT_IMPL(a_step_only_div, cmd_o.div_step, state_q == S_DIV_BW || state_q == S_DIV_USE)
  `NBRM_ASSERT_IMPL(a_load_idle, cmd_o.load_in, state_q == S_IDLE && !in_stall_o)

endmodule

/* rtl/nbrm_datapath.sv */
`include "node_bandwidth_rate_meter_macros.svh"

module nbrm_datapath import nbrm_pkg::*; #(
  parameter int NODES = NodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  node_index_i,
  input  logic [63:0] traffic_count_i,
  input  logic [63:0] time_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  node_out_o,
  output logic [2:0]  sample_status_o,
  output logic [31:0] bandwidth_q8_o,
  output logic [16:0] usage_q16_o
);

  localparam int IdxW = (NODES > 1) ? $clog2(NODES) : 1;

  // per-node state
  logic [63:0] base_q [NODES];
  logic [63:0] last_q [NODES];
  logic [31:0] held_bw_q [NODES];
  logic [16:0] held_use_q [NODES];
  logic [NODES-1:0] primed_q;

  // captured sample and intermediate values
  logic [1:0]    n_q;
  logic [63:0]   cnt_q, time_q;
  logic [63:0]   dus_q, delta_q;
  logic          bwd_q;
  logic [25:0]   lim_q;
  logic [83:0]   prod_q;
  logic [IdxW-1:0] idx;

  // result under construction and its state updates
  logic [2:0]  res_st_q;
  logic [31:0] res_bw_q;
  logic [16:0] res_use_q;
  logic        wr_held_q, wr_base_q, set_primed_q;

  // decision taken from the captured sample
  logic [2:0]  dec_st;
  logic [31:0] dec_bw;
  logic [16:0] dec_use;
  logic        dec_held, dec_base, dec_primed;

  // shared bit-serial divider
  logic [63:0] rem_q, dvs_q;
  logic [31:0] sh_q, quo_q;
  logic [64:0] r2, r2_sub;
  logic        ge;
  logic [63:0] rem_d;
  logic [31:0] quo_d;

  logic        out_valid_q;
  logic [1:0]  out_node_q;
  logic [2:0]  out_st_q;
  logic [31:0] out_bw_q;
  logic [16:0] out_use_q;

  logic        bad, manual, early, zero_t, measure;
  logic [19:0] mx;
  logic [64:0] sub65;
  logic [19:0] scale;
  logic [31:0] mul_a;
  logic [51:0] pp;
  logic [83:0] num;
  logic [51:0] num_hi;
  logic        sat;
  logic        use_zero, use_full;

  assign idx = n_q[IdxW-1:0];
  assign mx  = cfg_i.max_bw[n_q];

  assign bad    = ({1'b0, n_q} >= cfg_i.active_nodes) || ({1'b0, n_q} >= 3'(NODES));
  assign manual = cfg_i.mode[1];
  assign early  = dus_q < {38'd0, lim_q};
  assign zero_t = (dus_q == '0);
  assign measure = !bad && !manual && primed_q[idx] && !early && !zero_t && !bwd_q;

  assign sub65 = {1'b0, cnt_q} - {1'b0, base_q[idx]};

  assign scale = (cfg_i.mode == MODE_PAGES) ? ScalePages : ScaleBytes;
  assign mul_a = cmd_i.mul_hi ? delta_q[63:32] : delta_q[31:0];
  assign pp    = mul_a * scale;

  assign num    = (cfg_i.mode == MODE_PAGES) ? prod_q : {6'd0, prod_q[83:6]};
  assign num_hi = num[83:32];
  // quotient reaches 2^32 exactly when the upper part is not below the divisor
  assign sat    = {12'd0, num_hi} >= dus_q;

  assign use_zero = (mx == '0);
  assign use_full = res_bw_q[31:8] >= {4'd0, mx};

  assign r2     = {rem_q, sh_q[31]};
  assign r2_sub = r2 - {1'b0, dvs_q};
  assign ge     = r2 >= {1'b0, dvs_q};
  assign rem_d  = ge ? r2_sub[63:0] : r2[63:0];
  assign quo_d  = {quo_q[30:0], ge};

  assign sts_o.measure  = measure;
  assign sts_o.sat      = sat;
  assign sts_o.use_done = use_zero || use_full;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    dec_st     = ST_COMPUTED;
    dec_bw     = held_bw_q[idx];
    dec_use    = held_use_q[idx];
    dec_held   = 1'b0;
    dec_base   = 1'b0;
    dec_primed = 1'b0;
    if (bad) begin
      dec_st  = ST_BAD_NODE;
      dec_bw  = '0;
      dec_use = '0;
    end else if (manual) begin
      dec_st   = ST_MANUAL;
      dec_bw   = {5'd0, mx, 7'd0};
      dec_use  = UsageHalf;
      dec_held = 1'b1;
    end else if (!primed_q[idx]) begin
      dec_st     = ST_BASELINE;
      dec_base   = 1'b1;
      dec_primed = 1'b1;
    end else if (early) begin
      dec_st = ST_EARLY;
    end else if (zero_t) begin
      dec_st = ST_ZERO_TIME;
    end else if (bwd_q) begin
      dec_st   = ST_BACKWARDS;
      dec_bw   = '0;
      dec_use  = '0;
      dec_held = 1'b1;
      dec_base = 1'b1;
    end else begin
      dec_held = 1'b1;
      dec_base = 1'b1;
    end
  end

  // sample capture and arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      n_q    <= node_index_i;
      cnt_q  <= traffic_count_i;
      time_q <= time_us_i;
    end
    if (cmd_i.diff) begin
      dus_q   <= time_q - last_q[idx];
      delta_q <= sub65[63:0];
      bwd_q   <= sub65[64];
      lim_q   <= 26'(cfg_i.interval_ms) * 26'(MsToUs);
    end
    if (cmd_i.mul_lo) begin
      prod_q <= {32'd0, pp};
    end
    if (cmd_i.mul_hi) begin
      prod_q <= prod_q + {pp, 32'd0};
    end
    if (cmd_i.pre_bw) begin
      rem_q <= {12'd0, num_hi};
      sh_q  <= num[31:0];
      dvs_q <= dus_q;
      quo_q <= '0;
    end
    if (cmd_i.pre_use) begin
      rem_q <= {40'd0, res_bw_q[31:8]};
      sh_q  <= {res_bw_q[7:0], 24'd0};
      dvs_q <= {44'd0, mx};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[30:0], 1'b0};
      quo_q <= quo_d;
    end
  end

  // result assembly
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_st_q     <= dec_st;
      res_bw_q     <= dec_bw;
      res_use_q    <= dec_use;
      wr_held_q    <= dec_held;
      wr_base_q    <= dec_base;
      set_primed_q <= dec_primed;
    end
    if (cmd_i.pre_bw && sat) begin
      res_bw_q <= BwSat;
    end
    if (cmd_i.take_bw) begin
      res_bw_q <= quo_d;
    end
    if (cmd_i.pre_use) begin
      if (use_zero) begin
        res_use_q <= '0;
      end else if (use_full) begin
        res_use_q <= UsageOne;
      end
    end
    if (cmd_i.take_use) begin
      res_use_q <= {1'b0, quo_d[15:0]};
    end
  end

  // node state, written back with the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_base_q) begin
      base_q[idx] <= cnt_q;
      last_q[idx] <= time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= '0;
      for (int i = 0; i < NODES; i++) begin
        held_bw_q[i]  <= '0;
        held_use_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (set_primed_q) begin
        primed_q[idx] <= 1'b1;
      end
      if (wr_held_q) begin
        held_bw_q[idx]  <= res_bw_q;
        held_use_q[idx] <= res_use_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_node_q <= n_q;
      out_st_q   <= res_st_q;
      out_bw_q   <= res_bw_q;
      out_use_q  <= res_use_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign node_out_o      = out_node_q;
  assign sample_status_o = out_st_q;
  assign bandwidth_q8_o  = out_bw_q;
  assign usage_q16_o     = out_use_q;

  `NBRM_ASSERT_IMPL(a_commit_free, cmd_i.commit, !out_valid_q || !out_stall_i)
  `NBRM_ASSERT_IMPL(a_rem_below, cmd_i.div_step, rem_q < dvs_q)
  `NBRM_ASSERT_IMPL(a_usage_range, out_valid_q, out_use_q <= UsageOne)
  `NBRM_ASSERT_IMPL(a_bad_zero, out_valid_q && out_st_q == ST_BAD_NODE,
                    out_bw_q == '0 && out_use_q == '0)

endmodule

/* verif/nbrm_checker.sv */
`timescale 1ns / 1ps

module nbrm_checker import nbrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  logic [1:0]       node_index_i,
  input  logic [63:0]      traffic_count_i,
  input  logic [63:0]      time_us_i,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [1:0]       node_out_o,
  input  logic [2:0]       sample_status_o,
  input  logic [31:0]      bandwidth_q8_o,
  input  logic [16:0]      usage_q16_o,
  output int               mismatches,
  output int               outstanding,
  output logic [6:0][15:0] status_hits
);

  typedef struct packed {
    logic [1:0]  node;
    logic [2:0]  status;
    logic [31:0] bw;
    logic [16:0] usage;
  } meter_result_t;

  meter_result_t expected_results[$];

  // Shadow copy of the register file
  logic [1:0]  meter_mode = MODE_BYTES;
  logic [15:0] gate_ms    = IntervalReset;
  logic [2:0]  live_nodes = ActiveReset;
  logic [19:0] node_max [MaxNodes];

  // Per-node measurement state
  logic [63:0] base_count [MaxNodes];
  logic [63:0] prev_time  [MaxNodes];
  logic        has_base   [MaxNodes];
  logic [31:0] hold_bw    [MaxNodes];
  logic [16:0] hold_use   [MaxNodes];

  int            error_count;
  int            hits [7];
  meter_result_t want, got;

  function automatic logic [31:0] rate_q8(logic [63:0] delta, logic [63:0] dus,
                                          logic [1:0] md);
    logic [127:0] num;
    logic [127:0] quo;
    // bytes scale by 15625 / 2^6, pages by 1e6; the floor of the floor is exact
    if (md == MODE_BYTES) num = ({64'd0, delta} * 128'(ScaleBytes)) >> 6;
    else                  num = {64'd0, delta} * 128'(ScalePages);
    quo = num / {64'd0, dus};
    return (quo > 128'(BwSat)) ? BwSat : quo[31:0];
  endfunction

  function automatic logic [16:0] usage_q16(logic [31:0] bw, logic [19:0] mx);
    logic [39:0] u;
    if (mx == 20'd0) return 17'd0;
    u = {bw, 8'd0} / 40'(mx);
    return (u > 40'(UsageOne)) ? UsageOne : u[16:0];
  endfunction

  function automatic meter_result_t predict_sample(logic [1:0] n, logic [63:0] cnt,
                                                   logic [63:0] now);
    meter_result_t r;
    logic [63:0]   dus;
    r.node   = n;
    r.bw     = 32'd0;
    r.usage  = 17'd0;
    if (3'(n) >= live_nodes) begin
      r.status = ST_BAD_NODE;
      return r;
    end
    if (meter_mode != MODE_BYTES && meter_mode != MODE_PAGES) begin
      hold_bw[n]  = 32'(node_max[n]) * 32'd128;
      hold_use[n] = UsageHalf;
      r.status    = ST_MANUAL;
    end else if (!has_base[n]) begin
      base_count[n] = cnt;
      prev_time[n]  = now;
      has_base[n]   = 1'b1;
      r.status      = ST_BASELINE;
    end else begin
      // time deltas wrap, so a step back in time looks like a long wait
      dus = now - prev_time[n];
      if (dus / 64'(MsToUs) < 64'(gate_ms)) begin
        r.status = ST_EARLY;
      end else if (dus == 64'd0) begin
        r.status = ST_ZERO_TIME;
      end else begin
        if (cnt >= base_count[n]) begin
          hold_bw[n]  = rate_q8(cnt - base_count[n], dus, meter_mode);
          hold_use[n] = usage_q16(hold_bw[n], node_max[n]);
          r.status    = ST_COMPUTED;
        end else begin
          hold_bw[n]  = 32'd0;
          hold_use[n] = 17'd0;
          r.status    = ST_BACKWARDS;
        end
        base_count[n] = cnt;
        prev_time[n]  = now;
      end
    end
    r.bw    = hold_bw[n];
    r.usage = hold_use[n];
    return r;
  endfunction

  function automatic void apply_register(logic [AddrW-3:0] idx, logic [DataW-1:0] val);
    case (idx)
      REG_MODE:     meter_mode  = val[1:0];
      REG_INTERVAL: gate_ms     = val[15:0];
      REG_ACTIVE:   live_nodes  = val[2:0];
      REG_MAX0:     node_max[0] = val[19:0];
      REG_MAX1:     node_max[1] = val[19:0];
      REG_MAX2:     node_max[2] = val[19:0];
      REG_MAX3:     node_max[3] = val[19:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_mode  = MODE_BYTES;
      gate_ms     = IntervalReset;
      live_nodes  = ActiveReset;
      error_count = 0;
      expected_results.delete();
      for (int i = 0; i < MaxNodes; i++) begin
        node_max[i]   = MaxBwReset;
        base_count[i] = 64'd0;
        prev_time[i]  = 64'd0;
        has_base[i]   = 1'b0;
        hold_bw[i]    = 32'd0;
        hold_use[i]   = 17'd0;
      end
      for (int i = 0; i < 7; i++) hits[i] = 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_register(paddr[AddrW-1:2], pwdata);

      if (out_valid_o && !out_stall_i) begin
        got = '{node_out_o, sample_status_o, bandwidth_q8_o, usage_q16_o};
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result for node %0d (status %0d) with no sample outstanding",
                     $realtime, got.node, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.node !== want.node || got.status !== want.status ||
              got.bw !== want.bw || got.usage !== want.usage) begin
            error_count++;
            if (error_count <= 10)
              $display({"%0t: mismatch: expected node %0d status %0d bw %h usage %h,",
                        " got node %0d status %0d bw %h usage %h"}, $realtime,
                       want.node, want.status, want.bw, want.usage,
                       got.node, got.status, got.bw, got.usage);
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        want = predict_sample(node_index_i, traffic_count_i, time_us_i);
        expected_results.push_back(want);
        hits[want.status]++;
      end
    end
    outstanding <= expected_results.size();
    mismatches  <= error_count;
    for (int i = 0; i < 7; i++) status_hits[i] <= 16'(hits[i]);
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import nbrm_pkg::*;

  localparam logic [1:0] ModeManual    = 2'd2;
  localparam int         TimeoutCycles = 600_000;
  localparam int         Phases        = 12;
  localparam int         PhaseItems    = 120;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       node_index_i = 2'd0;
  logic [63:0]      traffic_count_i = 64'd0;
  logic [63:0]      time_us_i = 64'd0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       node_out_o;
  logic [2:0]       sample_status_o;
  logic [31:0]      bandwidth_q8_o;
  logic [16:0]      usage_q16_o;

  int               mismatches;
  int               outstanding;
  logic [6:0][15:0] status_hits;

  // Stimulus-side view of the settings and of each node's counter and clock
  logic [1:0]  mode_now;
  int          interval_now;
  logic [19:0] max_now [4];
  logic [63:0] node_clock [4];
  logic [63:0] node_count [4];

  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit quiet     = 1'b0;
  int items_sent = 0;
  int settings_done = 0;

  node_bandwidth_rate_meter u_dut (.*);
  nbrm_checker u_checker (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls in random bursts; no new burst starts while quiet
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left  <= $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #(TimeoutCycles * 10);
    $display("[node_bandwidth_rate_meter] ERROR");
    $finish;
  end

  task automatic send_sample(input logic [1:0] n, input logic [63:0] cnt,
                             input logic [63:0] t);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    node_index_i    <= n;
    traffic_count_i <= cnt;
    time_us_i       <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Let the last transfer show in the outstanding count before waiting for it to clear
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [1:0] md, input int ivl, input int act,
                           input int m0, input int m1, input int m2, input int m3);
    drain();
    apb_write(REG_MODE, 32'(md));
    apb_write(REG_INTERVAL, 32'(ivl));
    apb_write(REG_ACTIVE, 32'(act));
    apb_write(REG_MAX0, 32'(m0));
    apb_write(REG_MAX1, 32'(m1));
    apb_write(REG_MAX2, 32'(m2));
    apb_write(REG_MAX3, 32'(m3));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mode_now     = md;
    interval_now = ivl;
    max_now[0]   = 20'(m0);
    max_now[1]   = 20'(m1);
    max_now[2]   = 20'(m2);
    max_now[3]   = 20'(m3);
    settings_done++;
  endtask

  function automatic int pick_max();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1048575)
                                       : $urandom_range(1000, 100000);
  endfunction

  // Mostly well-formed measurements, with early, zero-time, backwards and noise mixed in
  task automatic random_sample();
    logic [1:0]  n;
    logic [63:0] dus, delta, cnt, t;
    int          kind, frac;
    n    = 2'($urandom_range(0, 3));
    kind = $urandom_range(0, 99);
    dus  = 64'(interval_now) * 64'd1000 + 64'($urandom_range(0, 3_000_000));
    if (kind < 8) begin
      cnt = {$urandom, $urandom};
      t   = {$urandom, $urandom};
      node_count[n] = cnt;
      node_clock[n] = t;
    end else if (kind < 16) begin
      cnt = node_count[n] + 64'($urandom);
      t   = (interval_now == 0) ? node_clock[n]
          : node_clock[n] + 64'($urandom_range(0, interval_now * 1000 - 1));
    end else if (kind < 20) begin
      cnt = node_count[n] - 64'($urandom_range(1, 1 << 30));
      t   = node_clock[n] + dus;
      node_count[n] = cnt;
      node_clock[n] = t;
    end else if (kind < 23) begin
      cnt = node_count[n] + 64'($urandom);
      t   = node_clock[n] - 64'($urandom_range(1, 1_000_000));
      node_count[n] = cnt;
      node_clock[n] = t;
    end else if (kind < 26) begin
      cnt = node_count[n] + 64'($urandom);
      t   = node_clock[n];
    end else begin
      // aim the rate at 0..130 percent of the node's maximum
      frac = $urandom_range(0, 130);
      if (mode_now == MODE_PAGES)
        delta = dus * 64'(max_now[n]) * 64'(frac) / 64'd409600;
      else
        delta = dus * 64'(max_now[n]) * 64'(frac) / 64'd100;
      if ($urandom_range(0, 9) == 0) delta = {$urandom, $urandom} >> $urandom_range(0, 63);
      cnt = node_count[n] + delta;
      t   = node_clock[n] + dus;
      node_count[n] = cnt;
      node_clock[n] = t;
    end
    send_sample(n, cnt, t);
  endtask

  initial begin
    logic [1:0] md;
    int         sel;
    for (int i = 0; i < 4; i++) begin
      max_now[i]    = MaxBwReset;
      node_clock[i] = 64'd0;
      node_count[i] = 64'd0;
    end
    mode_now     = MODE_BYTES;
    interval_now = int'(IntervalReset);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting at reset settings: 100 ms gate, 50000 MB/s maxima
    send_sample(2'd0, 64'd0, 64'd0);
    send_sample(2'd0, 64'd1000, 64'd99_999);
    send_sample(2'd0, 64'd5_000_000_000, 64'd100_000);
    send_sample(2'd0, 64'd1, 64'd200_000);
    send_sample(2'd0, '1, 64'd300_000);
    send_sample(2'd1, '1, '1);
    send_sample(2'd1, '1, 64'd99_999);
    send_sample(2'd2, 64'd0, 64'h8000_0000_0000_0000);
    send_sample(2'd2, 64'h0000_0001_0000_0000, 64'd0);
    send_sample(2'd3, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_sample(2'd3, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAB_C8CA);
    configure(MODE_PAGES, 100, 4, 50000, 50000, 50000, 50000);
    send_sample(2'd3, 64'hAAAA_AAAA_AAAA_AAAA + 64'd1000, 64'hAAAA_AAAA_AAAD_E7EA);
    send_sample(2'd0, '1, 64'd400_000);
    configure(MODE_BYTES, 0, 4, 50000, 50000, 50000, 50000);
    send_sample(2'd3, 64'hAAAA_AAAA_AAAA_AAAA + 64'd5000, 64'hAAAA_AAAA_AAAD_E7EA);
    send_sample(2'd2, 64'h0000_0001_0000_1000, 64'd1);
    configure(MODE_BYTES, 100, 1, 50000, 50000, 50000, 50000);
    send_sample(2'd3, 64'd7, 64'd7);
    send_sample(2'd1, 64'd7, 64'd7);
    send_sample(2'd0, '1, 64'd500_000);
    configure(ModeManual, 100, 4, 1, 1048575, 50000, 50000);
    send_sample(2'd0, 64'd0, 64'd0);
    send_sample(2'd1, '1, '1);
    send_sample(2'd3, 64'd0, 64'd0);

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: configure(MODE_BYTES, 100, 4, 50000, 50000, 50000, 50000);
        1: configure(MODE_BYTES, 0, 4, 1, 1048575, 30000, 80000);
        2: configure(MODE_PAGES, 65535, 4, 1048575, 1, 20000, 50000);
        3: configure(ModeManual, 10, 2, 1, 1048575, 7, 12345);
        4: configure(MODE_BYTES, 5, 1, pick_max(), pick_max(), pick_max(), pick_max());
        5: configure(MODE_PAGES, 0, 3, pick_max(), pick_max(), pick_max(), pick_max());
        default: begin
          sel = $urandom_range(0, 99);
          md  = (sel < 45) ? MODE_BYTES : (sel < 85) ? MODE_PAGES : ModeManual;
          configure(md, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 200),
                    $urandom_range(1, 4), pick_max(), pick_max(), pick_max(), pick_max());
        end
      endcase
      // in the closing phase, add no input gaps and start no new receiver stalls
      quiet = (p == Phases - 1);
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 15; stall_pct = 20; end
        default: begin gap_pct = 40; stall_pct = 45; end
      endcase
      for (int k = 0; k < PhaseItems; k++) random_sample();
    end

    drain();
    repeat (60) @(posedge clk_i);
    $display("run: %0d samples under %0d register settings", items_sent, settings_done);
    $display({"statuses: baseline %0d, early %0d, zero time %0d, measured %0d,",
              " counter backwards %0d, manual %0d, bad node %0d"},
             status_hits[ST_BASELINE], status_hits[ST_EARLY], status_hits[ST_ZERO_TIME],
             status_hits[ST_COMPUTED], status_hits[ST_BACKWARDS], status_hits[ST_MANUAL],
             status_hits[ST_BAD_NODE]);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[node_bandwidth_rate_meter] OK");
    end else begin
      $display("[node_bandwidth_rate_meter] ERROR");
    end
    $finish;
  end

endmodule
